/* src/crc8fr_pkg.sv */
// ----------------------------------------------------------------------------
// CRC-8 frame checker package
// Shared types, codes and the CRC-8 lookup table used by the frame receiver.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   localparam logic REG_OWN_ADDRESS = 1'b0;
   localparam logic REG_END_MARK    = 1'b1;

   localparam logic [7:0] OWN_ADDRESS_RESET = 8'h00;
   localparam logic [7:0] END_MARK_RESET    = 8'h21;

   // Frame bytes that the verdict needs: address, message id and four data bytes.
   localparam int HEAD_BYTES = 6;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_BAD_LENGTH    = 2'd1,
      ST_CRC_MISMATCH  = 2'd2,
      ST_OTHER_ADDRESS = 2'd3
   } status_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [7:0]  message_id;
      logic [31:0] value;
   } verdict_type;

   typedef struct packed {
      logic        en;
      logic [7:0]  addr;
      logic [31:0] data;
   } tbl_write_type;

   localparam logic [7:0] KOOP_LUT [256] = '{
      8'hea, 8'hd4, 8'h96, 8'ha8, 8'h12, 8'h2c, 8'h6e, 8'h50,
      8'h7f, 8'h41, 8'h03, 8'h3d, 8'h87, 8'hb9, 8'hfb, 8'hc5,
      8'ha5, 8'h9b, 8'hd9, 8'he7, 8'h5d, 8'h63, 8'h21, 8'h1f,
      8'h30, 8'h0e, 8'h4c, 8'h72, 8'hc8, 8'hf6, 8'hb4, 8'h8a,
      8'h74, 8'h4a, 8'h08, 8'h36, 8'h8c, 8'hb2, 8'hf0, 8'hce,
      8'he1, 8'hdf, 8'h9d, 8'ha3, 8'h19, 8'h27, 8'h65, 8'h5b,
      8'h3b, 8'h05, 8'h47, 8'h79, 8'hc3, 8'hfd, 8'hbf, 8'h81,
      8'hae, 8'h90, 8'hd2, 8'hec, 8'h56, 8'h68, 8'h2a, 8'h14,
      8'hb3, 8'h8d, 8'hcf, 8'hf1, 8'h4b, 8'h75, 8'h37, 8'h09,
      8'h26, 8'h18, 8'h5a, 8'h64, 8'hde, 8'he0, 8'ha2, 8'h9c,
      8'hfc, 8'hc2, 8'h80, 8'hbe, 8'h04, 8'h3a, 8'h78, 8'h46,
      8'h69, 8'h57, 8'h15, 8'h2b, 8'h91, 8'haf, 8'hed, 8'hd3,
      8'h2d, 8'h13, 8'h51, 8'h6f, 8'hd5, 8'heb, 8'ha9, 8'h97,
      8'hb8, 8'h86, 8'hc4, 8'hfa, 8'h40, 8'h7e, 8'h3c, 8'h02,
      8'h62, 8'h5c, 8'h1e, 8'h20, 8'h9a, 8'ha4, 8'he6, 8'hd8,
      8'hf7, 8'hc9, 8'h8b, 8'hb5, 8'h0f, 8'h31, 8'h73, 8'h4d,
      8'h58, 8'h66, 8'h24, 8'h1a, 8'ha0, 8'h9e, 8'hdc, 8'he2,
      8'hcd, 8'hf3, 8'hb1, 8'h8f, 8'h35, 8'h0b, 8'h49, 8'h77,
      8'h17, 8'h29, 8'h6b, 8'h55, 8'hef, 8'hd1, 8'h93, 8'had,
      8'h82, 8'hbc, 8'hfe, 8'hc0, 8'h7a, 8'h44, 8'h06, 8'h38,
      8'hc6, 8'hf8, 8'hba, 8'h84, 8'h3e, 8'h00, 8'h42, 8'h7c,
      8'h53, 8'h6d, 8'h2f, 8'h11, 8'hab, 8'h95, 8'hd7, 8'he9,
      8'h89, 8'hb7, 8'hf5, 8'hcb, 8'h71, 8'h4f, 8'h0d, 8'h33,
      8'h1c, 8'h22, 8'h60, 8'h5e, 8'he4, 8'hda, 8'h98, 8'ha6,
      8'h01, 8'h3f, 8'h7d, 8'h43, 8'hf9, 8'hc7, 8'h85, 8'hbb,
      8'h94, 8'haa, 8'he8, 8'hd6, 8'h6c, 8'h52, 8'h10, 8'h2e,
      8'h4e, 8'h70, 8'h32, 8'h0c, 8'hb6, 8'h88, 8'hca, 8'hf4,
      8'hdb, 8'he5, 8'ha7, 8'h99, 8'h23, 8'h1d, 8'h5f, 8'h61,
      8'h9f, 8'ha1, 8'he3, 8'hdd, 8'h67, 8'h59, 8'h1b, 8'h25,
      8'h0a, 8'h34, 8'h76, 8'h48, 8'hf2, 8'hcc, 8'h8e, 8'hb0,
      8'hd0, 8'hee, 8'hac, 8'h92, 8'h28, 8'h16, 8'h54, 8'h6a,
      8'h45, 8'h7b, 8'h39, 8'h07, 8'hbd, 8'h83, 8'hc1, 8'hff
   };

endpackage

/* src/crc8fr_frame.sv */
// ----------------------------------------------------------------------------
// CRC-8 frame collector
// Counts frame bytes, runs the CRC byte by byte and judges a frame at its stop byte.
// ----------------------------------------------------------------------------
module crc8fr_frame #(
   parameter int FRAME_DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_en,
   input  logic [7:0]               rx_byte,
   input  logic [7:0]               own_address,
   input  logic [7:0]               end_mark,
   output crc8fr_pkg::verdict_type   verdict,
   output crc8fr_pkg::tbl_write_type tbl_write
);

   localparam int CW = $clog2(FRAME_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C    = CW'(FRAME_DEPTH);
   localparam logic [CW-1:0] LEN5_COUNT = CW'(4);
   localparam logic [CW-1:0] LEN8_COUNT = CW'(7);

   logic [CW-1:0] count_ff, count_in;
   logic          overrun_ff, overrun_in;
   logic [7:0]    crc_ff, crc_in;
   logic [7:0]    crc_prev_ff, crc_prev_in;
   logic [7:0]    last_ff, last_in;
   logic [31:0]   held_ff, held_in;
   logic [7:0]    head_ff [crc8fr_pkg::HEAD_BYTES];

   logic        room;
   logic        is_stop;
   logic        len_ok;
   logic        frame_ok;
   logic [31:0] new_word;
   crc8fr_pkg::status_type status;

   always_comb begin
      room    = (count_ff != DEPTH_C);
      is_stop = (rx_byte == end_mark);
      // The stop byte itself is not stored, so a 5-byte frame ends with four bytes already held.
      len_ok  = room && !overrun_ff && (count_ff == LEN5_COUNT || count_ff == LEN8_COUNT);

      if (count_ff == LEN5_COUNT) begin
         new_word = {held_ff[31:8], head_ff[2]};
      end else begin
         new_word = {head_ff[5], head_ff[4], head_ff[3], head_ff[2]};
      end

      if (!len_ok) begin
         status = crc8fr_pkg::ST_BAD_LENGTH;
      end else if (last_ff != crc_prev_ff) begin
         status = crc8fr_pkg::ST_CRC_MISMATCH;
      end else if (head_ff[0] != own_address) begin
         status = crc8fr_pkg::ST_OTHER_ADDRESS;
      end else begin
         status = crc8fr_pkg::ST_OK;
      end
      frame_ok = byte_en && is_stop && (status == crc8fr_pkg::ST_OK);

      verdict.valid      = byte_en && is_stop;
      verdict.status     = status;
      verdict.message_id = len_ok ? head_ff[1] : 8'h00;
      verdict.value      = frame_ok ? new_word : held_ff;

      tbl_write.en   = frame_ok;
      tbl_write.addr = head_ff[1];
      tbl_write.data = new_word;

      count_in    = count_ff;
      overrun_in  = overrun_ff;
      crc_in      = crc_ff;
      crc_prev_in = crc_prev_ff;
      last_in     = last_ff;
      held_in     = frame_ok ? new_word : held_ff;
      if (byte_en) begin
         if (is_stop) begin
            count_in   = '0;
            overrun_in = 1'b0;
            crc_in     = 8'h00;
         end else if (room) begin
            count_in    = count_ff + CW'(1);
            crc_prev_in = crc_ff;
            crc_in      = crc8fr_pkg::KOOP_LUT[crc_ff ^ rx_byte];
            last_in     = rx_byte;
         end else begin
            overrun_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         overrun_ff <= 1'b0;
         crc_ff     <= 8'h00;
         held_ff    <= 32'h0;
      end else begin
         count_ff   <= count_in;
         overrun_ff <= overrun_in;
         crc_ff     <= crc_in;
         held_ff    <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_prev_ff <= crc_prev_in;
      last_ff     <= last_in;
   end

   for (genvar i = 0; i < crc8fr_pkg::HEAD_BYTES; i++) begin : g_head
      always_ff @(posedge clock) begin
         if (byte_en && !is_stop && count_ff == CW'(i)) begin
            head_ff[i] <= rx_byte;
         end
      end
   end

endmodule

/* src/crc8fr_table.sv */
// ----------------------------------------------------------------------------
// CRC-8 frame response table
// 256 by 32 synchronous memory with per-entry valid bits that read as zero.
// ----------------------------------------------------------------------------
module crc8fr_table (
   input  logic                      clock,
   input  logic                      reset,
   input  crc8fr_pkg::tbl_write_type tbl_write,
   input  logic                      rd_en,
   input  logic [7:0]                rd_addr,
   output logic [31:0]               rd_data
);

   logic [31:0]  mem [256];
   logic [255:0] valid_ff;
   logic [31:0]  rdata_ff;
   logic         rvalid_ff;

   always_ff @(posedge clock) begin
      if (tbl_write.en) begin
         mem[tbl_write.addr] <= tbl_write.data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (tbl_write.en) begin
            valid_ff[tbl_write.addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : 32'h0;

endmodule

/* src/crc8_frame_receive_checker.sv */
// ----------------------------------------------------------------------------
// CRC-8 framed message receiver and checker
// Path: a response is held in the first stage, then in the output register.
// Throughput: one request per cycle, bytes and table reads alike, while responses are taken.
// The rate holds because a request makes at most one table access and the CRC takes one byte.
// Reset clears the table's valid bits at once; no clearing pass is run.
// ----------------------------------------------------------------------------
//
// Requests carry either a received byte or a read of the response table. Bytes
// are collected into a frame; the stop byte closes it and produces a verdict.
// The CRC runs one byte per request, so the verdict is formed in the cycle the
// stop byte is accepted, and a good frame writes the table at that same edge.
// A later read therefore always sees the written entry: a single request never
// both reads and writes the table, so no forwarding is needed.
//
// The first stage holds the response next to the table's registered read data;
// the second stage is the output register. Requests keep flowing while a
// finished response waits to be taken, until the first stage is also full.
module crc8_frame_receive_checker #(
   parameter int FRAME_DEPTH = 10
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_read_index,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_message_id,
   output logic [31:0] rsp_value,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   // Configuration registers.
   logic [7:0] own_address_ff;
   logic [7:0] end_mark_ff;

   // First stage.
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_kind_ff;
   logic [1:0]  s1_status_ff;
   logic [7:0]  s1_id_ff;
   logic [31:0] s1_value_ff;

   // Output stage.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [1:0]  rsp_status_ff;
   logic [7:0]  rsp_id_ff;
   logic [31:0] rsp_value_ff;

   logic        accept;
   logic        byte_en;
   logic        read_en;
   logic        load_s1;
   logic        advance;
   logic [31:0] rd_data;

   crc8fr_pkg::verdict_type   verdict;
   crc8fr_pkg::tbl_write_type tbl_write;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= crc8fr_pkg::OWN_ADDRESS_RESET;
         end_mark_ff    <= crc8fr_pkg::END_MARK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            crc8fr_pkg::REG_OWN_ADDRESS: own_address_ff <= csr_data;
            crc8fr_pkg::REG_END_MARK:    end_mark_ff    <= csr_data;
            default:                     own_address_ff <= own_address_ff;
         endcase
      end
   end

   // The first stage moves on whenever the output register is free or is being
   // emptied in the same cycle; a request is taken whenever the first stage is empty or can move.
   always_comb begin
      advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !s1_valid_ff || advance;
      accept    = req_valid && req_ready;
      byte_en   = accept && (req_opcode == crc8fr_pkg::OP_BYTE);
      read_en   = accept && (req_opcode == crc8fr_pkg::OP_READ);
      load_s1   = read_en || verdict.valid;

      if (load_s1) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   crc8fr_frame #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .byte_en     (byte_en),
      .rx_byte     (req_rx_byte),
      .own_address (own_address_ff),
      .end_mark    (end_mark_ff),
      .verdict     (verdict),
      .tbl_write   (tbl_write)
   );

   crc8fr_table u_table (
      .clock     (clock),
      .reset     (reset),
      .tbl_write (tbl_write),
      .rd_en     (read_en),
      .rd_addr   (req_read_index),
      .rd_data   (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         if (read_en) begin
            s1_kind_ff   <= crc8fr_pkg::KIND_READ;
            s1_status_ff <= crc8fr_pkg::ST_OK;
            s1_id_ff     <= req_read_index;
            s1_value_ff  <= 32'h0;
         end else begin
            s1_kind_ff   <= crc8fr_pkg::KIND_VERDICT;
            s1_status_ff <= verdict.status;
            s1_id_ff     <= verdict.message_id;
            s1_value_ff  <= verdict.value;
         end
      end
      // The table's read data stays put until the next read, which cannot be
      // accepted before this stage has moved on.
      if (advance) begin
         rsp_kind_ff   <= s1_kind_ff;
         rsp_status_ff <= s1_status_ff;
         rsp_id_ff     <= s1_id_ff;
         rsp_value_ff  <= (s1_kind_ff == crc8fr_pkg::KIND_READ) ? rd_data : s1_value_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_message_id  = rsp_id_ff;
   assign rsp_value       = rsp_value_ff;

endmodule
